>>> rtl/opponent_color_transform_macros.svh
// ----------------------------------------------------------------------------
// opponent color transform assertion macros
// concurrent checks used by the top rtl file of the block
// ----------------------------------------------------------------------------
`ifndef OPPONENT_COLOR_TRANSFORM_MACROS_SVH
`define OPPONENT_COLOR_TRANSFORM_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define OCX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ocx assertion failed");

// next-cycle implication
`define OCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ocx assertion failed");

`else

`define OCX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OCX_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/ocx_pkg.sv
// ----------------------------------------------------------------------------
// ocx_pkg
// widths, coefficients, codes and rounding for the opponent color transform
// ----------------------------------------------------------------------------
package ocx_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int NUM_CH         = 4;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int TERM_W         = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
    localparam int SUM_W          = TERM_W + 2;
    localparam int TDATA_W        = ((NUM_CH * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int CFG_W          = 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [TERM_W-1:0]       term_t;
    typedef logic signed [SUM_W-1:0]        sum_t;

    typedef enum logic [1:0] {
        MODE_ONE   = 2'd0,
        MODE_THREE = 2'd1,
        MODE_BAYER = 2'd2
    } mode_t;

    typedef enum logic {
        REG_CHANNEL_MODE = 1'b0,
        REG_INVERSE_DIR  = 1'b1
    } cfg_index_t;

    // coefficients held at 24 fraction bits, rounded half up
    localparam longint K24_INV_SQRT3   = 9686330;
    localparam longint K24_INV_SQRT2   = 11863283;
    localparam longint K24_HALF_SQRT23 = 6849270;
    localparam int     K_SHIFT         = 24 - COEF_FRAC_BITS;
    localparam longint K_HALF          = (longint'(1) <<< K_SHIFT) >>> 1;

    localparam coef_t COEF_A = coef_t'((K24_INV_SQRT3 + K_HALF) >>> K_SHIFT);
    localparam coef_t COEF_B = coef_t'((K24_INV_SQRT2 + K_HALF) >>> K_SHIFT);
    localparam coef_t COEF_C = coef_t'((K24_HALF_SQRT23 + K_HALF) >>> K_SHIFT);

    localparam sum_t ROUND_HALF = sum_t'(longint'(1) <<< (COEF_FRAC_BITS - 1));
    localparam sum_t SAT_HI     = sum_t'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam sum_t SAT_LO     = -SAT_HI - sum_t'(1);

    typedef struct packed {
        sample_t value;
        logic    sat;
    } round_t;

    // add half, floor by the coefficient scale, clip to the sample range
    function automatic round_t round_sat(input sum_t acc);
        sum_t   r;
        sum_t   q;
        round_t res;
        r = acc + ROUND_HALF;
        q = r >>> COEF_FRAC_BITS;
        res.sat = 1'b0;
        if (q > SAT_HI) begin
            q       = SAT_HI;
            res.sat = 1'b1;
        end else if (q < SAT_LO) begin
            q       = SAT_LO;
            res.sat = 1'b1;
        end
        res.value = q[SAMPLE_WIDTH-1:0];
        return res;
    endfunction

endpackage

>>> rtl/opponent_color_transform.sv
// ----------------------------------------------------------------------------
// opponent_color_transform
// orthonormal opponent / bayer haar color transform, one pixel per beat
// ----------------------------------------------------------------------------
// s_ channel: one pixel per beat, four signed samples with 4 fraction bits
// m_ channel: the transformed pixel, clip flag in m_tuser
// cfg port: index 0 channel mode, index 1 inverse direction; write only
// while no pixel is in flight
// latency: 3 cycles from input beat to output beat (input register,
// product register, result register)
// throughput: one pixel per cycle; each stage is a constant-multiply or
// add-round-clip step between registers
// reset: pipeline empty, channel mode three channels, forward direction
// stall: when m_tready is low the result holds, the two earlier stages
// still fill, and s_tready falls once all three stages hold a pixel
// ----------------------------------------------------------------------------
`include "opponent_color_transform_macros.svh"

module opponent_color_transform
    import ocx_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // in_ch0, in_ch1, in_ch2, in_ch3
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_ch0, out_ch1, out_ch2, out_ch3
    output logic [0:0]         m_tuser,   // saturated
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    mode_t   mode_reg;
    logic    inv_reg;
    logic    in_valid_reg;
    logic    prod_valid_reg;
    logic    out_valid_reg;
    logic    en_in;
    logic    en_prod;
    logic    en_out;
    sample_t pix_reg [NUM_CH];
    term_t   term [NUM_CH][NUM_CH];
    sample_t ch [NUM_CH];
    logic    sat;

    assign en_out  = !out_valid_reg || m_tready;
    assign en_prod = !prod_valid_reg || en_out;
    assign en_in   = !in_valid_reg || en_prod;

    assign s_tready = en_in;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({ch[3], ch[2], ch[1], ch[0]});
    assign m_tuser  = sat;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_THREE;
            inv_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_CHANNEL_MODE: mode_reg <= mode_t'(cfg_wdata[1:0]);
                REG_INVERSE_DIR:  inv_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (en_in) begin
                in_valid_reg <= s_tvalid;
            end
            if (en_prod) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (en_out) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (en_in && s_tvalid) begin
            for (int i = 0; i < NUM_CH; i++) begin
                pix_reg[i] <= s_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
            end
        end
    end

    ocx_product_stage u_product (
        .aclk     (aclk),
        .en       (en_prod),
        .mode     (mode_reg),
        .inverse  (inv_reg),
        .x        (pix_reg),
        .term_reg (term)
    );

    ocx_round_stage u_round (
        .aclk    (aclk),
        .en      (en_out),
        .term    (term),
        .ch_reg  (ch),
        .sat_reg (sat)
    );

    `OCX_ASSERT_NEXT(a_accept_fills_input, aclk, aresetn, s_tvalid && s_tready, in_valid_reg)
    `OCX_ASSERT_NEXT(a_result_moves_up, aclk, aresetn, prod_valid_reg && !m_tvalid, m_tvalid)
    `OCX_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn, !s_tready,
        in_valid_reg && prod_valid_reg && m_tvalid)
    `OCX_ASSERT_IMPL(a_sat_at_limit, aclk, aresetn, m_tvalid && sat,
        ch[0] == SAT_HI[SAMPLE_WIDTH-1:0] || ch[0] == SAT_LO[SAMPLE_WIDTH-1:0] ||
        ch[1] == SAT_HI[SAMPLE_WIDTH-1:0] || ch[1] == SAT_LO[SAMPLE_WIDTH-1:0] ||
        ch[2] == SAT_HI[SAMPLE_WIDTH-1:0] || ch[2] == SAT_LO[SAMPLE_WIDTH-1:0] ||
        ch[3] == SAT_HI[SAMPLE_WIDTH-1:0] || ch[3] == SAT_LO[SAMPLE_WIDTH-1:0])

endmodule

>>> rtl/ocx_product_stage.sv
// ----------------------------------------------------------------------------
// ocx_product_stage
// constant products of the samples, selected into signed terms per output
// ----------------------------------------------------------------------------
module ocx_product_stage
    import ocx_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  mode_t   mode,
    input  logic    inverse,
    input  sample_t x [NUM_CH],
    output term_t   term_reg [NUM_CH][NUM_CH]
);

    term_t pa [NUM_CH];
    term_t pb [NUM_CH];
    term_t pc [NUM_CH];
    term_t ph [NUM_CH];
    term_t term_next [NUM_CH][NUM_CH];

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            pa[i] = term_t'(x[i]) * term_t'(COEF_A);
            pb[i] = term_t'(x[i]) * term_t'(COEF_B);
            pc[i] = term_t'(x[i]) * term_t'(COEF_C);
            ph[i] = term_t'(x[i]) <<< (COEF_FRAC_BITS - 1);
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_CH; j++) begin
            for (int i = 0; i < NUM_CH; i++) begin
                term_next[j][i] = '0;
            end
        end
        unique case (mode)
            MODE_ONE: begin
                term_next[0][0] = term_t'(x[0]) <<< COEF_FRAC_BITS;
            end
            MODE_THREE: begin
                if (!inverse) begin
                    term_next[0][0] = pa[0];
                    term_next[0][1] = pa[1];
                    term_next[0][2] = pa[2];
                    term_next[1][0] = pb[0];
                    term_next[1][1] = -pb[2];
                    term_next[2][0] = pc[0];
                    term_next[2][1] = -(pc[1] <<< 1);
                    term_next[2][2] = pc[2];
                end else begin
                    term_next[0][0] = pa[0];
                    term_next[0][1] = pb[1];
                    term_next[0][2] = pc[2];
                    term_next[1][0] = pa[0];
                    term_next[1][1] = -(pc[2] <<< 1);
                    term_next[2][0] = pa[0];
                    term_next[2][1] = -pb[1];
                    term_next[2][2] = pc[2];
                end
            end
            default: begin
                if (!inverse) begin
                    term_next[0][0] = ph[0];
                    term_next[0][1] = ph[1];
                    term_next[0][2] = ph[2];
                    term_next[0][3] = ph[3];
                    term_next[1][0] = pb[1];
                    term_next[1][1] = -pb[2];
                    term_next[2][0] = -ph[0];
                    term_next[2][1] = ph[1];
                    term_next[2][2] = ph[2];
                    term_next[2][3] = -ph[3];
                    term_next[3][0] = pb[3];
                    term_next[3][1] = -pb[0];
                end else begin
                    term_next[0][0] = ph[0];
                    term_next[0][1] = -ph[2];
                    term_next[0][2] = -pb[3];
                    term_next[1][0] = ph[0];
                    term_next[1][1] = pb[1];
                    term_next[1][2] = ph[2];
                    term_next[2][0] = ph[0];
                    term_next[2][1] = -pb[1];
                    term_next[2][2] = ph[2];
                    term_next[3][0] = ph[0];
                    term_next[3][1] = -ph[2];
                    term_next[3][2] = pb[3];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            term_reg <= term_next;
        end
    end

endmodule

>>> rtl/ocx_round_stage.sv
// ----------------------------------------------------------------------------
// ocx_round_stage
// sums the terms of each output, rounds, saturates and flags clipping
// ----------------------------------------------------------------------------
module ocx_round_stage
    import ocx_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  term_t   term [NUM_CH][NUM_CH],
    output sample_t ch_reg [NUM_CH],
    output logic    sat_reg
);

    round_t  res [NUM_CH];
    sample_t ch_next [NUM_CH];
    logic    sat_next;

    always_comb begin
        sat_next = 1'b0;
        for (int j = 0; j < NUM_CH; j++) begin
            res[j] = round_sat(sum_t'(term[j][0]) + sum_t'(term[j][1])
                             + sum_t'(term[j][2]) + sum_t'(term[j][3]));
            ch_next[j] = res[j].value;
            sat_next   = sat_next | res[j].sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ch_reg  <= ch_next;
            sat_reg <= sat_next;
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opponent_color_transform testbench
// drives pixels over the s_ stream with random gaps and stalls the m_ stream
// at random, checks every output beat field by field against a fixed-point
// prediction or the directed table's result; the table covers extremes, all
// channel modes and directions, rounding halves and masked register bits,
// then random phases run under changing register settings
// ----------------------------------------------------------------------------
module tb;
    import ocx_pkg::*;

    localparam int     FRAC_BITS   = 16;
    localparam int     K_SH        = 24 - FRAC_BITS;
    localparam longint C_A         = (64'sd9686330 + ((64'sd1 <<< K_SH) >>> 1)) >>> K_SH;
    localparam longint C_B         = (64'sd11863283 + ((64'sd1 <<< K_SH) >>> 1)) >>> K_SH;
    localparam longint C_C         = (64'sd6849270 + ((64'sd1 <<< K_SH) >>> 1)) >>> K_SH;
    localparam longint C_C2        = 2 * C_C;
    localparam longint C_H         = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint S_MAX       = 32767;
    localparam longint S_MIN       = -32768;
    localparam int     LATENCY     = 3;
    localparam int     HOLD_CYCLES = 100;
    localparam int     N_PHASES    = 13;
    localparam int     N_DIRECTED  = 21;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] DIR_FWD    = 2'd0;
    localparam logic [1:0] DIR_INV    = 2'd1;
    localparam logic [1:0] DIR_FWD_HI = 2'd2;
    localparam logic [1:0] DIR_INV_HI = 2'd3;

    typedef logic [3:0][15:0] pix_t;

    typedef struct {
        pix_t data;
        logic sat;
    } result_t;

    // pixels written ch3_ch2_ch1_ch0
    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] inv;
        pix_t       px;
        logic       typed;
        pix_t       res;
        logic       res_sat;
    } vec_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;
    logic               cfg_we    = 1'b0;
    logic [0:0]         cfg_index = REG_CHANNEL_MODE;
    logic [CFG_W-1:0]   cfg_wdata = '0;

    logic [1:0] cur_mode_raw = MODE_THREE;
    logic [1:0] cur_inv_raw  = DIR_FWD;
    bit         send_burst   = 1'b0;
    bit         recv_burst   = 1'b0;
    bit         hold_req     = 1'b0;
    int         mismatches   = 0;
    result_t    out_pixels_q [$];

    vec_t directed_vecs [N_DIRECTED] = '{
        '{MODE_THREE, DIR_FWD,    64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000, 1'b0},
        '{MODE_THREE, DIR_FWD,    64'h1234_7fff_7fff_7fff, 1'b1, 64'h0000_0000_0000_7fff, 1'b1},
        '{MODE_THREE, DIR_FWD,    64'h0000_8000_8000_8000, 1'b1, 64'h0000_0000_0000_8000, 1'b1},
        '{MODE_THREE, DIR_FWD,    64'h0000_0030_0020_0010, 1'b0, 64'h0, 1'b0},
        '{MODE_THREE, DIR_INV,    64'h0000_7fff_7fff_7fff, 1'b0, 64'h0, 1'b0},
        '{MODE_THREE, DIR_INV,    64'h0000_8000_7fff_8000, 1'b0, 64'h0, 1'b0},
        '{MODE_THREE, DIR_INV,    64'h5555_0008_fff0_0010, 1'b0, 64'h0, 1'b0},
        '{MODE_ONE,   DIR_FWD,    64'h7fff_7fff_7fff_8000, 1'b1, 64'h0000_0000_0000_8000, 1'b0},
        '{MODE_ONE,   DIR_INV,    64'habcd_1234_8000_7fff, 1'b1, 64'h0000_0000_0000_7fff, 1'b0},
        '{MODE_BAYER, DIR_FWD,    64'h7fff_7fff_7fff_7fff, 1'b1, 64'h0000_0000_0000_7fff, 1'b1},
        '{MODE_BAYER, DIR_FWD,    64'h8000_8000_8000_8000, 1'b1, 64'h0000_0000_0000_8000, 1'b1},
        '{MODE_BAYER, DIR_FWD,    64'h0000_0000_0000_0001, 1'b1, 64'hffff_0000_0000_0001, 1'b0},
        '{MODE_BAYER, DIR_FWD,    64'h7fff_8000_7fff_8000, 1'b0, 64'h0, 1'b0},
        '{MODE_BAYER, DIR_INV,    64'h7fff_7fff_7fff_7fff, 1'b0, 64'h0, 1'b0},
        '{MODE_BAYER, DIR_INV,    64'h8000_8000_8000_8000, 1'b0, 64'h0, 1'b0},
        '{MODE_BAYER, DIR_INV,    64'hfff9_0007_fffd_0003, 1'b0, 64'h0, 1'b0},
        '{MODE_SPARE, DIR_FWD,    64'h4444_3333_2222_1111, 1'b0, 64'h0, 1'b0},
        '{MODE_SPARE, DIR_INV,    64'h8000_7fff_0000_8000, 1'b0, 64'h0, 1'b0},
        '{MODE_THREE, DIR_FWD_HI, 64'hffff_0300_0200_0100, 1'b0, 64'h0, 1'b0},
        '{MODE_THREE, DIR_INV_HI, 64'h0000_0001_8000_7fff, 1'b0, 64'h0, 1'b0},
        '{MODE_THREE, DIR_FWD,    64'hffff_ffff_ffff_ffff, 1'b0, 64'h0, 1'b0}
    };

    opponent_color_transform u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL opponent_color_transform");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 30) begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endtask

    // {clip, value}: add half, floor, clip to the sample range
    function automatic logic [16:0] round_clip(input longint acc);
        longint q;
        logic   clip;
        clip = 1'b0;
        q    = (acc + C_H) >>> FRAC_BITS;
        if (q > S_MAX) begin
            q    = S_MAX;
            clip = 1'b1;
        end else if (q < S_MIN) begin
            q    = S_MIN;
            clip = 1'b1;
        end
        return {clip, q[15:0]};
    endfunction

    function automatic result_t transform_pixel(input pix_t px);
        longint      x0, x1, x2, x3;
        longint      acc [4];
        logic [16:0] rc;
        result_t     r;
        int          nch;
        x0     = longint'($signed(px[0]));
        x1     = longint'($signed(px[1]));
        x2     = longint'($signed(px[2]));
        x3     = longint'($signed(px[3]));
        r.data = '0;
        r.sat  = 1'b0;
        acc    = '{0, 0, 0, 0};
        if (cur_mode_raw == MODE_ONE) begin
            r.data[0] = px[0];
            return r;
        end
        if (cur_mode_raw == MODE_THREE) begin
            nch = 3;
            if (!cur_inv_raw[0]) begin
                acc[0] = C_A * x0 + C_A * x1 + C_A * x2;
                acc[1] = C_B * x0 - C_B * x2;
                acc[2] = C_C * x0 - C_C2 * x1 + C_C * x2;
            end else begin
                acc[0] = C_A * x0 + C_B * x1 + C_C * x2;
                acc[1] = C_A * x0 - C_C2 * x2;
                acc[2] = C_A * x0 - C_B * x1 + C_C * x2;
            end
        end else begin
            nch = 4;
            if (!cur_inv_raw[0]) begin
                acc[0] = C_H * x0 + C_H * x1 + C_H * x2 + C_H * x3;
                acc[1] = C_B * x1 - C_B * x2;
                acc[2] = -C_H * x0 + C_H * x1 + C_H * x2 - C_H * x3;
                acc[3] = C_B * x3 - C_B * x0;
            end else begin
                acc[0] = C_H * x0 - C_H * x2 - C_B * x3;
                acc[1] = C_H * x0 + C_B * x1 + C_H * x2;
                acc[2] = C_H * x0 - C_B * x1 + C_H * x2;
                acc[3] = C_H * x0 - C_H * x2 + C_B * x3;
            end
        end
        for (int i = 0; i < nch; i++) begin
            rc        = round_clip(acc[i]);
            r.data[i] = rc[15:0];
            r.sat     = r.sat | rc[16];
        end
        return r;
    endfunction

    function automatic int pick_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 4))
            0, 1:    return 16'($urandom);
            2:       return 16'($urandom_range(0, 255)) - 16'd128;
            3:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 2047))
                                                 : 16'h8000 + 16'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic pix_t draw_pixel();
        pix_t px;
        for (int i = 0; i < 4; i++) begin
            px[i] = draw_sample();
        end
        return px;
    endfunction

    task automatic send_pixel(input pix_t px, input int gap, input bit typed,
                              input result_t typed_res);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        out_pixels_q.push_back(typed ? typed_res : transform_pixel(px));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (out_pixels_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_format(input logic [1:0] mode_raw, input logic [1:0] inv_raw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHANNEL_MODE;
        cfg_wdata <= mode_raw;
        @(posedge aclk);
        cfg_index <= REG_INVERSE_DIR;
        cfg_wdata <= inv_raw;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        cur_mode_raw  = mode_raw;
        cur_inv_raw   = inv_raw;
    endtask

    // result side
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                recv_burst = !recv_burst;
            end
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = pick_wait(recv_burst);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        pix_t    got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (out_pixels_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", got));
            end else begin
                want = out_pixels_q.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== want.data[i]) begin
                        report_mismatch($sformatf("out_ch%0d got %0d want %0d", i,
                                        $signed(got[i]), $signed(want.data[i])));
                    end
                end
                if (m_tuser[0] !== want.sat) begin
                    report_mismatch($sformatf("saturated got %b want %b", m_tuser[0],
                                    want.sat));
                end
            end
        end
    end

    // pixel side and register settings
    initial begin
        vec_t        v;
        result_t     typed_res;
        logic [1:0]  pm, pi;
        int          n;
        logic [1:0]  phase_mode [7] = '{MODE_THREE, MODE_THREE, MODE_BAYER, MODE_BAYER,
                                         MODE_ONE, MODE_SPARE, MODE_THREE};
        logic [1:0]  phase_inv [7]  = '{DIR_FWD, DIR_INV, DIR_FWD, DIR_INV,
                                         DIR_FWD, DIR_INV, DIR_FWD_HI};
        typed_res.data = '0;
        typed_res.sat  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            v = directed_vecs[i];
            if (v.mode != cur_mode_raw || v.inv != cur_inv_raw) begin
                drain_pipeline();
                set_format(v.mode, v.inv);
            end
            typed_res.data = v.res;
            typed_res.sat  = v.res_sat;
            send_pixel(v.px, pick_wait(send_burst), v.typed, typed_res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 7) begin
                pm = phase_mode[p];
                pi = phase_inv[p];
            end else begin
                pm = 2'($urandom_range(0, 3));
                pi = 2'($urandom_range(0, 3));
            end
            drain_pipeline();
            set_format(pm, pi);
            if (p == 1) begin
                // fill the pipeline while the result side holds off
                hold_req = 1'b1;
                for (int k = 0; k < 30; k++) begin
                    send_pixel(draw_pixel(), 0, 1'b0, typed_res);
                end
            end
            n = $urandom_range(80, 120);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_burst = !send_burst;
                end
                send_pixel(draw_pixel(), pick_wait(send_burst), 1'b0, typed_res);
            end
        end

        drain_pipeline();
        repeat (LATENCY + 5) @(posedge aclk);
        if (out_pixels_q.size() != 0) begin
            report_mismatch($sformatf("%0d beats never arrived", out_pixels_q.size()));
        end
        if (mismatches == 0) begin
            $display("PASS opponent_color_transform");
        end else begin
            $display("FAIL opponent_color_transform");
        end
        $finish;
    end

endmodule
